/* design/ini_key_value_tokenizer_unit_defines.svh */
// assertion macros shared by the tokenizer checker
// no dependencies; included by files that hold concurrent assertions
`ifndef INI_KEY_VALUE_TOKENIZER_UNIT_DEFINES_SVH
`define INI_KEY_VALUE_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define IKVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ikvt assertion failed");

// next-cycle implication, disabled in reset
`define IKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ikvt assertion failed");

`endif

/* design/ikvt_pkg.sv */
// types, constants and byte classes for the ini key/value tokenizer
// no dependencies
`default_nettype none

package ikvt_pkg;

    localparam int OffsetBits = 16;
    localparam int FieldBits  = 16;

    localparam logic [OffsetBits-1:0] TopOffset = {OffsetBits{1'b1}};

    localparam logic [7:0] ChEquals  = 8'h3d;
    localparam logic [7:0] ChNewline = 8'h0a;
    localparam logic [7:0] ChReturn  = 8'h0d;
    localparam logic [7:0] ChTab     = 8'h09;
    localparam logic [7:0] ChSpace   = 8'h20;

    typedef enum logic [2:0] {
        PH_SKIP_WS     = 3'd0,
        PH_READ_KEY    = 3'd1,
        PH_PRE_EQUALS  = 3'd2,
        PH_POST_EQUALS = 3'd3,
        PH_SKIP_LINE   = 3'd4,
        PH_READ_VALUE  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [FieldBits-1:0] key_offset;
        logic [FieldBits-1:0] key_length;
        logic [FieldBits-1:0] value_offset;
        logic [FieldBits-1:0] value_length;
        logic                 offset_overflow;
    } t_out_item;

    function automatic logic is_space_tab(input logic [7:0] c);
        return (c == ChSpace) || (c == ChTab);
    endfunction

    function automatic logic is_newline(input logic [7:0] c);
        return (c == ChNewline) || (c == ChReturn);
    endfunction

endpackage

`default_nettype wire

/* design/ikvt_parser.sv */
// six-phase parse machine with offset counter and stored token bounds
// depends on ikvt_pkg
`default_nettype none

module ikvt_parser import ikvt_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_item  i_item,
    output logic           o_emit,
    output t_out_item      o_result
);

    t_phase                r_phase, n_phase;
    logic [OffsetBits-1:0] r_pos, n_pos;
    logic [OffsetBits-1:0] r_key_begin, n_key_begin;
    logic [OffsetBits-1:0] r_key_finish, n_key_finish;
    logic [OffsetBits-1:0] r_value_begin, n_value_begin;
    logic                  r_saturated, n_saturated;

    logic [7:0]            c;
    logic                  sp_tab, nl, ws, eq;
    logic [OffsetBits-1:0] key_len, value_len;

    assign c      = i_item.text_byte;
    assign sp_tab = is_space_tab(c);
    assign nl     = is_newline(c);
    assign ws     = sp_tab || nl;
    assign eq     = (c == ChEquals);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_READ_KEY: begin
                if (sp_tab) begin
                    n_phase = PH_PRE_EQUALS;
                end else if (nl) begin
                    n_phase = PH_SKIP_WS;
                end else if (eq) begin
                    n_phase = PH_POST_EQUALS;
                end
            end
            PH_PRE_EQUALS: begin
                if (eq) begin
                    n_phase = PH_POST_EQUALS;
                end else if (!sp_tab) begin
                    n_phase = PH_SKIP_LINE;
                end
            end
            PH_SKIP_LINE: begin
                if (nl) begin
                    n_phase = PH_SKIP_WS;
                end
            end
            PH_POST_EQUALS: begin
                if (nl) begin
                    n_phase = PH_SKIP_WS;
                end else if (!sp_tab) begin
                    n_phase = PH_READ_VALUE;
                end
            end
            PH_READ_VALUE: begin
                if (ws) begin
                    n_phase = PH_SKIP_WS;
                end
            end
            default: begin
                // skip whitespace, also covers the unused codes
                if (!ws) begin
                    n_phase = PH_READ_KEY;
                end
            end
        endcase
        if (i_item.last_byte) begin
            n_phase = PH_SKIP_WS;
        end
    end

    // token bounds and offset counter
    always_comb begin
        n_key_begin   = r_key_begin;
        n_key_finish  = r_key_finish;
        n_value_begin = r_value_begin;
        case (r_phase) inside
            PH_READ_KEY: begin
                if (sp_tab || eq) begin
                    n_key_finish = r_pos;
                end
            end
            PH_POST_EQUALS: begin
                if (!ws) begin
                    n_value_begin = r_pos;
                end
            end
            PH_PRE_EQUALS, PH_SKIP_LINE, PH_READ_VALUE: begin
            end
            default: begin
                if (!ws) begin
                    n_key_begin = r_pos;
                end
            end
        endcase

        if (r_pos == TopOffset) begin
            n_pos       = r_pos;
            n_saturated = 1'b1;
        end else begin
            n_pos       = r_pos + OffsetBits'(1);
            n_saturated = r_saturated;
        end

        if (i_item.last_byte) begin
            n_pos         = '0;
            n_saturated   = 1'b0;
            n_key_begin   = '0;
            n_key_finish  = '0;
            n_value_begin = '0;
        end
    end

    // result of this byte
    assign key_len   = r_key_finish - r_key_begin;
    assign value_len = r_pos - r_value_begin;

    always_comb begin
        o_emit                   = (r_phase == PH_READ_VALUE) && ws;
        o_result.key_offset      = FieldBits'(r_key_begin);
        o_result.key_length      = FieldBits'(key_len);
        o_result.value_offset    = FieldBits'(r_value_begin);
        o_result.value_length    = FieldBits'(value_len);
        o_result.offset_overflow = r_saturated;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SKIP_WS;
            r_pos         <= '0;
            r_key_begin   <= '0;
            r_key_finish  <= '0;
            r_value_begin <= '0;
            r_saturated   <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_key_begin   <= n_key_begin;
            r_key_finish  <= n_key_finish;
            r_value_begin <= n_value_begin;
            r_saturated   <= n_saturated;
        end
    end

endmodule

`default_nettype wire

/* design/ini_key_value_tokenizer_unit.sv */
// channel   | dir | handshake              | payload
// ----------+-----+------------------------+-----------
// in        | in  | i_in_valid / o_in_stall  | t_in_item
// out       | out | o_out_valid / i_out_stall | t_out_item
//
// one byte per cycle while the input is not stalled; a pair leaves in the cycle after the byte that ends it
// the parse state sits in the parser registers, the result in one output register
// input stalls only while the output register holds an item that is stalled
// synchronous active-low reset returns to skip-whitespace at offset zero
// depends on ikvt_pkg and ikvt_parser
`default_nettype none

module ini_key_value_tokenizer_unit import ikvt_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    logic      accept;
    logic      emit;
    t_out_item result;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    ikvt_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_item   (i_in_item),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

/* design/ikvt_checker.sv */
// port-level checks for the tokenizer, bound to the top level
// depends on ikvt_pkg and the assertion macro header
`default_nettype none
`include "ini_key_value_tokenizer_unit_defines.svh"

module ikvt_checker import ikvt_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    logic in_acc;
    logic out_held;
    logic r_after_last;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_held = o_out_valid && i_out_stall;

    // set while the most recent accepted item was a final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_last <= 1'b0;
        end else if (in_acc) begin
            r_after_last <= i_in_item.last_byte;
        end
    end

    // a stalled result item stays and holds its payload
    `IKVT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_item))

    // input is held back only behind a stalled result
    `IKVT_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, out_held)

    // a fresh result needs an item accepted the cycle before
    `IKVT_ASSERT_NOW(a_out_source, i_clk, i_rst_n, o_out_valid && !$past(out_held), $past(in_acc))

    // the first byte of a new buffer cannot end a pair
    `IKVT_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, in_acc && r_after_last, !o_out_valid)

endmodule

bind ini_key_value_tokenizer_unit ikvt_checker u_ikvt_checker (.*);

`default_nettype wire
